[hdl/ipe_pkg.sv]
// ----------------------------------------------------------------------------
// ipe_pkg
// Types and command codes shared by the infix precedence evaluator.
// ----------------------------------------------------------------------------
package ipe_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 3;

  localparam logic [CmdW-1:0] CMD_ADD = 3'd0;
  localparam logic [CmdW-1:0] CMD_SUB = 3'd1;
  localparam logic [CmdW-1:0] CMD_MUL = 3'd2;
  localparam logic [CmdW-1:0] CMD_DIV = 3'd3;
  localparam logic [CmdW-1:0] CMD_POW = 3'd4;
  localparam logic [CmdW-1:0] CMD_EQU = 3'd5;

  typedef struct packed {
    logic signed [DataW-1:0] operand_value;
    logic [CmdW-1:0]         command;
  } token_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic                    error_flag;
  } result_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic div_by_zero;
  } div_stat_t;

endpackage

[hdl/ipe_mul.sv]
// ----------------------------------------------------------------------------
// ipe_mul
// Shared 32x32 multiplier, low word of the product, registered output.
// ----------------------------------------------------------------------------
module ipe_mul (
  input  logic                       clk,
  input  logic [ipe_pkg::DataW-1:0]  a,
  input  logic [ipe_pkg::DataW-1:0]  b,
  output logic [ipe_pkg::DataW-1:0]  p_r
);
  import ipe_pkg::*;

  logic [DataW-1:0] p_nxt;

  // low word is the same for signed and unsigned operands
  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

[hdl/ipe_div.sv]
// ----------------------------------------------------------------------------
// ipe_div
// Iterative signed divider, one quotient bit per cycle, truncates toward
// zero. Divide by zero gives 0 and raises div_by_zero with done.
// ----------------------------------------------------------------------------
module ipe_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ipe_pkg::DataW-1:0]  dividend,
  input  logic [ipe_pkg::DataW-1:0]  divisor,
  output ipe_pkg::div_stat_t         stat,
  output logic [ipe_pkg::DataW-1:0]  quotient
);
  import ipe_pkg::*;

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic             active_r, active_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] quo_r, quo_nxt;
  logic [DataW-1:0] dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic             finish;

  assign rem_sh = {rem_r, quo_r[DataW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign finish = active_r && (cnt_r == '0);

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    neg_nxt    = neg_r;
    zero_nxt   = zero_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = CntW'(DataW);
      rem_nxt    = '0;
      quo_nxt    = dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt    = divisor[DataW-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt    = dividend[DataW-1] ^ divisor[DataW-1];
      zero_nxt   = (divisor == '0);
    end else if (finish) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!diff[DataW]) begin
        rem_nxt = diff[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign stat.done        = finish;
  assign stat.div_by_zero = zero_r;
  assign quotient = zero_r ? '0 : (neg_r ? (~quo_r + 1'b1) : quo_r);

endmodule

[hdl/infix_precedence_evaluator.sv]
// ----------------------------------------------------------------------------
// infix_precedence_evaluator
// Token-stream calculator with three precedence levels and iterative units.
// ----------------------------------------------------------------------------
// Each input word is an operand and the operator that follows it. Power binds
// tightest, then multiply/divide, then add/subtract; every level runs left to
// right and all arithmetic wraps to 32 bits. Equals emits the value with a
// sticky error flag (divide by zero, zero to a negative power) and clears the
// expression. The block takes one word at a time. Closing a pending multiply
// goes through the shared multiplier, and closing a pending divide waits for
// the bit-serial divider, which gives one quotient bit per cycle. A word that
// follows a power with a non-negative exponent first runs square-and-multiply
// through the one shared multiplier, over the exponent bits up to the highest
// set one. A finished result sits in an output register, and the next word is
// taken while it waits; output back-pressure stalls the input only when a new
// result is ready before the previous one has left.
module infix_precedence_evaluator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ipe_pkg::token_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ipe_pkg::result_t out_data
);
  import ipe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POW  = 3'd1;
  localparam logic [2:0] ST_PROD = 3'd2;
  localparam logic [2:0] ST_MULW = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  localparam logic [1:0] PH_ACC  = 2'd0;
  localparam logic [1:0] PH_TAKE = 2'd1;
  localparam logic [1:0] PH_SQ   = 2'd2;

  localparam int unsigned IdxW = $clog2(DataW);

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic [DataW-1:0] acc_r, acc_nxt;
  logic [DataW-1:0] sq_r, sq_nxt;
  logic [DataW-1:0] expo_r, expo_nxt;
  logic [CmdW-1:0]  cmd_r, cmd_nxt;
  logic [DataW-1:0] factor_r, factor_nxt;
  logic [DataW-1:0] term_r, term_nxt;

  logic [DataW-1:0] run_val_r, run_val_nxt;
  logic [CmdW-1:0]  run_op_r, run_op_nxt;
  logic             started_r, started_nxt;
  logic [DataW-1:0] sum_val_r, sum_val_nxt;
  logic             sum_minus_r, sum_minus_nxt;
  logic             sum_vld_r, sum_vld_nxt;
  logic [DataW-1:0] prod_val_r, prod_val_nxt;
  logic             prod_div_r, prod_div_nxt;
  logic             prod_vld_r, prod_vld_nxt;
  logic             err_r, err_nxt;

  logic             out_valid_r, out_valid_nxt;
  result_t          out_data_r, out_data_nxt;

  logic [DataW-1:0] mul_a, mul_b, mul_p;
  logic             div_start;
  div_stat_t        div_stat;
  logic [DataW-1:0] div_q;
  logic [DataW-1:0] sum;
  logic             accept;
  logic             out_free;

  ipe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  ipe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_val_r),
    .divisor  (factor_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sum = !sum_vld_r ? term_r :
               (sum_minus_r ? (sum_val_r - term_r) : (sum_val_r + term_r));

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    expo_nxt      = expo_r;
    cmd_nxt       = cmd_r;
    factor_nxt    = factor_r;
    term_nxt      = term_r;
    run_val_nxt   = run_val_r;
    run_op_nxt    = run_op_r;
    started_nxt   = started_r;
    sum_val_nxt   = sum_val_r;
    sum_minus_nxt = sum_minus_r;
    sum_vld_nxt   = sum_vld_r;
    prod_val_nxt  = prod_val_r;
    prod_div_nxt  = prod_div_r;
    prod_vld_nxt  = prod_vld_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mul_a         = acc_r;
    mul_b         = sq_r;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // codes above equals are dropped without touching state
        if (accept && (in_data.command <= CMD_EQU)) begin
          cmd_nxt     = in_data.command;
          expo_nxt    = in_data.operand_value;
          factor_nxt  = in_data.operand_value;
          started_nxt = 1'b1;
          run_op_nxt  = in_data.command;
          state_nxt   = ST_PROD;
          if (started_r && (run_op_r == CMD_POW)) begin
            if (in_data.operand_value[DataW-1]) begin
              // negative exponent: integer part only
              if (run_val_r == '0) begin
                factor_nxt = '0;
                err_nxt    = 1'b1;
              end else if (run_val_r == DataW'(1)) begin
                factor_nxt = DataW'(1);
              end else if (run_val_r == '1) begin
                factor_nxt = in_data.operand_value[0] ? '1 : DataW'(1);
              end else begin
                factor_nxt = '0;
              end
            end else begin
              acc_nxt   = DataW'(1);
              sq_nxt    = run_val_r;
              idx_nxt   = '0;
              ph_nxt    = PH_ACC;
              state_nxt = ST_POW;
            end
          end
        end
      end

      ST_POW: begin
        unique case (ph_r)
          PH_ACC: begin
            // stop once no exponent bits remain
            if ((expo_r >> idx_r) == '0) begin
              factor_nxt = acc_r;
              state_nxt  = ST_PROD;
            end else if (expo_r[idx_r]) begin
              ph_nxt = PH_TAKE;
            end else begin
              mul_a  = sq_r;
              ph_nxt = PH_SQ;
            end
          end
          PH_TAKE: begin
            acc_nxt = mul_p;
            mul_a   = sq_r;
            ph_nxt  = PH_SQ;
          end
          PH_SQ: begin
            sq_nxt = mul_p;
            if (idx_r == IdxW'(DataW - 2)) begin
              factor_nxt = acc_r;
              state_nxt  = ST_PROD;
            end else begin
              idx_nxt = idx_r + 1'b1;
              ph_nxt  = PH_ACC;
            end
          end
          default: begin
            ph_nxt = PH_ACC;
          end
        endcase
      end

      ST_PROD: begin
        if (cmd_r == CMD_POW) begin
          run_val_nxt = factor_r;
          state_nxt   = ST_IDLE;
        end else begin
          run_val_nxt = '0;
          if (!prod_vld_r) begin
            term_nxt  = factor_r;
            state_nxt = ST_SUM;
          end else if (prod_div_r) begin
            div_start = 1'b1;
            state_nxt = ST_DIVW;
          end else begin
            mul_a     = prod_val_r;
            mul_b     = factor_r;
            state_nxt = ST_MULW;
          end
        end
      end

      ST_MULW: begin
        term_nxt  = mul_p;
        state_nxt = ST_SUM;
      end

      ST_DIVW: begin
        if (div_stat.done) begin
          term_nxt  = div_q;
          err_nxt   = err_r | div_stat.div_by_zero;
          state_nxt = ST_SUM;
        end
      end

      ST_SUM: begin
        state_nxt = ST_IDLE;
        if ((cmd_r == CMD_MUL) || (cmd_r == CMD_DIV)) begin
          prod_val_nxt = term_r;
          prod_div_nxt = (cmd_r == CMD_DIV);
          prod_vld_nxt = 1'b1;
        end else begin
          prod_val_nxt = '0;
          prod_div_nxt = 1'b0;
          prod_vld_nxt = 1'b0;
          if ((cmd_r == CMD_ADD) || (cmd_r == CMD_SUB)) begin
            sum_val_nxt   = sum;
            sum_minus_nxt = (cmd_r == CMD_SUB);
            sum_vld_nxt   = 1'b1;
          end else begin
            term_nxt  = sum;
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_value = term_r;
          out_data_nxt.error_flag   = err_r;
          run_val_nxt   = '0;
          run_op_nxt    = CMD_ADD;
          started_nxt   = 1'b0;
          sum_val_nxt   = '0;
          sum_minus_nxt = 1'b0;
          sum_vld_nxt   = 1'b0;
          prod_val_nxt  = '0;
          prod_div_nxt  = 1'b0;
          prod_vld_nxt  = 1'b0;
          err_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_ACC;
      run_val_r   <= '0;
      run_op_r    <= CMD_ADD;
      started_r   <= 1'b0;
      sum_val_r   <= '0;
      sum_minus_r <= 1'b0;
      sum_vld_r   <= 1'b0;
      prod_val_r  <= '0;
      prod_div_r  <= 1'b0;
      prod_vld_r  <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      run_val_r   <= run_val_nxt;
      run_op_r    <= run_op_nxt;
      started_r   <= started_nxt;
      sum_val_r   <= sum_val_nxt;
      sum_minus_r <= sum_minus_nxt;
      sum_vld_r   <= sum_vld_nxt;
      prod_val_r  <= prod_val_nxt;
      prod_div_r  <= prod_div_nxt;
      prod_vld_r  <= prod_vld_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    expo_r     <= expo_nxt;
    cmd_r      <= cmd_nxt;
    factor_r   <= factor_nxt;
    term_r     <= term_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the infix precedence evaluator. Token words go in
// through a valid/stall channel. A predictor in this bench evaluates them with
// the same precedence rules; each result word is checked in order against it,
// or a typed row's want. A short directed table comes first, then random
// expressions in three idling phases, long back-pressure and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
  import ipe_pkg::*;

  // command codes above equals: the block drops these words
  localparam logic [CmdW-1:0] CMD_IGN_LO = 3'd6;
  localparam logic [CmdW-1:0] CMD_IGN_HI = 3'd7;

  localparam int StuckLimit = 4000;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 200;

  typedef struct packed {
    token_t  tok;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  token_t  in_data   = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  result_t out_data;

  // side info that travels with the word on the input channel
  logic    tok_typed = 1'b0;
  result_t tok_want  = '0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int mismatches   = 0;

  result_t result_q[$];

  // evaluator state as the block should hold it
  logic [31:0]     pow_base   = '0;
  logic [CmdW-1:0] last_cmd   = CMD_ADD;
  logic            expr_open  = 1'b0;
  logic [31:0]     sum_acc    = '0;
  logic            sum_neg    = 1'b0;
  logic            sum_live   = 1'b0;
  logic [31:0]     prod_acc   = '0;
  logic            prod_div   = 1'b0;
  logic            prod_live  = 1'b0;
  logic            err_sticky = 1'b0;

  // operand, command, typed flag, expected value, expected error
  stim_row_t dir_rows [25] = '{
    {32'sd7,          CMD_EQU,    1'b1, 32'sd7,          1'b0},
    {32'sh7fff_ffff,  CMD_ADD,    1'b0, 33'd0},
    {32'sd1,          CMD_EQU,    1'b1, 32'sh8000_0000,  1'b0},
    {32'sh8000_0000,  CMD_DIV,    1'b0, 33'd0},
    {-32'sd1,         CMD_EQU,    1'b1, 32'sh8000_0000,  1'b0},
    {32'sd5,          CMD_DIV,    1'b0, 33'd0},
    {32'sd0,          CMD_EQU,    1'b1, 32'sd0,          1'b1},
    {32'sd0,          CMD_POW,    1'b0, 33'd0},
    {-32'sd3,         CMD_EQU,    1'b1, 32'sd0,          1'b1},
    {32'sd0,          CMD_POW,    1'b0, 33'd0},
    {32'sd0,          CMD_EQU,    1'b1, 32'sd1,          1'b0},
    {32'sd1,          CMD_POW,    1'b0, 33'd0},
    {-32'sd5,         CMD_SUB,    1'b0, 33'd0},
    {-32'sd1,         CMD_POW,    1'b0, 33'd0},
    {-32'sd3,         CMD_ADD,    1'b0, 33'd0},
    {-32'sd1,         CMD_POW,    1'b0, 33'd0},
    {-32'sd4,         CMD_ADD,    1'b0, 33'd0},
    {32'sd7,          CMD_POW,    1'b0, 33'd0},
    {-32'sd2,         CMD_MUL,    1'b0, 33'd0},
    {32'sd9,          CMD_IGN_LO, 1'b0, 33'd0},
    {-32'sd9,         CMD_IGN_HI, 1'b0, 33'd0},
    {32'sd3,          CMD_DIV,    1'b0, 33'd0},
    {32'sd4,          CMD_POW,    1'b0, 33'd0},
    {32'sd2,          CMD_SUB,    1'b0, 33'd0},
    {32'sd10,         CMD_EQU,    1'b0, 33'd0}
  };

  infix_precedence_evaluator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] div_wrap(logic [31:0] num, logic [31:0] den);
    longint sn;
    longint sd;
    longint quo;
    if (den == '0) begin
      err_sticky = 1'b1;
      return '0;
    end
    sn  = $signed(num);
    sd  = $signed(den);
    quo = sn / sd;
    return quo[31:0];
  endfunction

  function automatic logic [31:0] pow_wrap(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    logic [31:0] sq;
    int          i;
    acc = 32'd1;
    sq  = base;
    // negative exponent: only the integer part survives
    if (ex[31]) begin
      if (base == '0) begin
        err_sticky = 1'b1;
        return '0;
      end
      if (base == 32'd1) return 32'd1;
      if (base == '1) return ex[0] ? '1 : 32'd1;
      return '0;
    end
    for (i = 0; i < 31; i++) begin
      if (ex[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  // returns 1 when the word closes an expression
  function automatic bit calc_token(input token_t tok, output result_t res);
    logic [31:0]     v;
    logic [CmdW-1:0] cmd;
    logic [31:0]     factor;
    logic [31:0]     term;
    logic [31:0]     sum;
    v   = tok.operand_value;
    cmd = tok.command;
    res = '0;
    if (cmd > CMD_EQU) return 1'b0;

    factor    = (expr_open && last_cmd == CMD_POW) ? pow_wrap(pow_base, v) : v;
    expr_open = 1'b1;
    last_cmd  = cmd;
    if (cmd == CMD_POW) begin
      pow_base = factor;
      return 1'b0;
    end
    pow_base = '0;

    if (prod_live) term = prod_div ? div_wrap(prod_acc, factor) : prod_acc * factor;
    else term = factor;
    if (cmd == CMD_MUL || cmd == CMD_DIV) begin
      prod_acc  = term;
      prod_div  = (cmd == CMD_DIV);
      prod_live = 1'b1;
      return 1'b0;
    end
    prod_acc  = '0;
    prod_div  = 1'b0;
    prod_live = 1'b0;

    if (sum_live) sum = sum_neg ? sum_acc - term : sum_acc + term;
    else sum = term;
    if (cmd == CMD_ADD || cmd == CMD_SUB) begin
      sum_acc  = sum;
      sum_neg  = (cmd == CMD_SUB);
      sum_live = 1'b1;
      return 1'b0;
    end

    res.result_value = sum;
    res.error_flag   = err_sticky;
    last_cmd   = CMD_ADD;
    expr_open  = 1'b0;
    sum_acc    = '0;
    sum_neg    = 1'b0;
    sum_live   = 1'b0;
    err_sticky = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_operand(bit after_pow);
    if (after_pow && $urandom_range(9) < 6) return $urandom_range(0, 12);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 16) - 8;
      4: return '0;
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'd1;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input token_t tok, input logic typed, input result_t want);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= tok;
    tok_typed <= typed;
    tok_want  <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // well-formed expressions mostly, with dropped words and noise runs mixed in
  task automatic run_random(input int n_words);
    int              sent;
    int              len;
    int              k;
    bit              noise;
    token_t          tok;
    logic [CmdW-1:0] prev;
    sent = 0;
    prev = CMD_EQU;
    while (sent < n_words) begin
      noise = ($urandom_range(9) == 0);
      len   = $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(29) == 0) begin
          tok.operand_value = $urandom;
          tok.command       = CmdW'($urandom_range(CMD_IGN_LO, CMD_IGN_HI));
          send_word(tok, 1'b0, '0);
        end
        if (noise) tok.command = CmdW'($urandom_range(0, 7));
        else if (k == len - 1) tok.command = CMD_EQU;
        else tok.command = CmdW'($urandom_range(CMD_ADD, CMD_POW));
        tok.operand_value = pick_operand(prev == CMD_POW);
        send_word(tok, 1'b0, '0);
        if (tok.command <= CMD_EQU) begin
          sent++;
          prev = tok.command;
        end
      end
    end
  endtask

  // output back-pressure: random, or a long hold when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    result_t pred;
    result_t want;
    bit      closes;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        closes = calc_token(in_data, pred);
        if (closes) result_q.push_back(tok_typed ? tok_want : pred);
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %0d/%0b", $time,
                   out_data.result_value, out_data.error_flag);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $display("%0t: result_value expected %0d got %0d", $time,
                     want.result_value, out_data.result_value);
            mismatches++;
          end
          if (out_data.error_flag !== want.error_flag) begin
            $display("%0t: error_flag expected %0b got %0b", $time,
                     want.error_flag, out_data.error_flag);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
      if (stuck >= StuckLimit) break;
    end
    $display("%0t: no word moved for %0d cycles", $time, StuckLimit);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < 25; r++) begin
      send_word(dir_rows[r].tok, dir_rows[r].typed, dir_rows[r].want);
    end
    wait_drained();

    tx_idle_pct  = 6;
    rx_stall_pct = 66;
    hold_req     = 1'b1;
    run_random(530);
    wait_drained();

    tx_idle_pct  = 66;
    rx_stall_pct = 6;
    run_random(530);
    wait_drained();

    // no idling; one long hold fills the block while words keep coming
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    run_random(540);
    wait_drained();

    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
